// File: rtl/group_ordered_queue_top_macros.svh
// Assertion macros shared by the group ordered queue RTL.
`ifndef GROUP_ORDERED_QUEUE_TOP_MACROS_SVH
`define GROUP_ORDERED_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GOQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("group ordered queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GOQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("group ordered queue check failed");

`endif

// File: rtl/goq_pkg.sv
// Shared types and constants of the group ordered queue.
package goq_pkg;

    localparam int unsigned CAPACITY = 256;
    localparam int unsigned GROUPS   = 128;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned GROUP_W  = 7;
    localparam int unsigned NODE_W   = $clog2(CAPACITY);
    localparam int unsigned GIDX_W   = $clog2(GROUPS);
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    typedef enum logic
    {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        logic signed [VALUE_W-1:0] value;
        logic [GROUP_W-1:0]        group;
        logic [NODE_W-1:0]         next;
    } node_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EQ_ALLOC,
        ST_EQ_SPLICE,
        ST_EQ_LINK,
        ST_DQ_READ,
        ST_DQ_GROUP,
        ST_DONE
    } state_t;

endpackage

// File: rtl/goq_req_if.sv
// Request channel: one queue operation per word.
interface goq_req_if;
    logic                                  valid;
    logic                                  ready;
    goq_pkg::func_t                        func;
    logic signed [goq_pkg::VALUE_W-1:0]    item_value;
    logic [goq_pkg::GROUP_W-1:0]           item_group;

    modport source (output valid, output func, output item_value, output item_group,
                    input ready);
    modport sink (input valid, input func, input item_value, input item_group,
                  output ready);
endinterface

// File: rtl/goq_rsp_if.sv
// Response channel: one result word per operation.
interface goq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [goq_pkg::VALUE_W-1:0]    out_value;
    goq_pkg::status_t                      status;

    modport source (output valid, output out_value, output status, input ready);
    modport sink (input valid, input out_value, input status, output ready);
endinterface

// File: rtl/goq_ram.sv
// Generic simple dual-port RAM with a registered read port.
module goq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/group_ordered_queue_top.sv
// Top level of the group ordered queue (team queue over a linked node store).
// Each request word either enqueues a value with a group number or dequeues the
// head of the queue, and each request produces exactly one response word. An
// enqueued value is placed directly behind the last queued member of its group,
// or at the tail when no member of that group is queued; a dequeue returns the
// head value and recycles its node onto a free list. An enqueue into a full
// queue (256 values) is dropped with status 1, and a dequeue from an empty
// queue answers status 2; both leave the queue unchanged and return value 0.
// The queue lives in two RAMs with registered reads: a node store holding value,
// group and link of each node, and a table with the last queued node of each
// group; per-group presence bits, head, tail and the counters sit in flops.
// Operations run one at a time, and the spacing of accepted request words is
// set by the single write port and the registered read of the node store. A
// dropped enqueue or an empty dequeue goes straight to the response, and an
// enqueue into an empty queue writes its node at allocation; other enqueues
// read the old link node and write the new node, then relink the old one, and a
// dequeue reads the head, then checks its group. A finished response sits in
// an output register, so the next request word is accepted while it waits to
// be taken. No clearing pass is needed after reset.
`include "group_ordered_queue_top_macros.svh"

module group_ordered_queue_top (
    input  logic            clk,
    input  logic            rst_n,
    goq_req_if.sink         req,
    goq_rsp_if.source       rsp
);

    // Control and status registers.
    goq_pkg::state_t                    state_reg, state_next;
    logic [goq_pkg::NODE_W-1:0]         head_reg, head_next;
    logic [goq_pkg::NODE_W-1:0]         tail_reg, tail_next;
    logic [goq_pkg::CNT_W-1:0]          occ_reg, occ_next;
    logic [goq_pkg::NODE_W-1:0]         free_head_reg, free_head_next;
    logic [goq_pkg::CNT_W-1:0]          free_cnt_reg, free_cnt_next;
    logic [goq_pkg::CNT_W-1:0]          fresh_reg, fresh_next;
    logic [goq_pkg::GROUPS-1:0]         present_reg, present_next;
    logic                               out_valid_reg, out_valid_next;

    // Payload registers of the operation in flight and of the response.
    logic signed [goq_pkg::VALUE_W-1:0] op_value_reg, op_value_next;
    logic [goq_pkg::GROUP_W-1:0]        op_group_reg, op_group_next;
    logic [goq_pkg::NODE_W-1:0]         node_idx_reg, node_idx_next;
    logic [goq_pkg::NODE_W-1:0]         link_reg, link_next;
    logic                               splice_reg, splice_next;
    goq_pkg::node_t                     link_word_reg, link_word_next;
    logic signed [goq_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    goq_pkg::status_t                   res_status_reg, res_status_next;
    logic signed [goq_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    goq_pkg::status_t                   out_status_reg, out_status_next;

    // Node store port signals.
    logic                               node_wr_en;
    logic [goq_pkg::NODE_W-1:0]         node_wr_addr;
    goq_pkg::node_t                     node_wr_data;
    logic                               node_rd_en;
    logic [goq_pkg::NODE_W-1:0]         node_rd_addr;
    goq_pkg::node_t                     node_rd_data;

    // Group-last table port signals.
    logic                               glast_wr_en;
    logic [goq_pkg::GIDX_W-1:0]         glast_wr_addr;
    logic [goq_pkg::NODE_W-1:0]         glast_wr_data;
    logic                               glast_rd_en;
    logic [goq_pkg::GIDX_W-1:0]         glast_rd_addr;
    logic [goq_pkg::NODE_W-1:0]         glast_rd_data;

    // Helpers for the operation in flight.
    logic [goq_pkg::GIDX_W-1:0]         group_idx;
    logic                               group_here;
    logic                               use_free;
    logic [goq_pkg::NODE_W-1:0]         alloc_idx;
    logic                               splice;
    logic [goq_pkg::NODE_W-1:0]         link_idx;

    goq_ram #(
        .WIDTH ($bits(goq_pkg::node_t)),
        .DEPTH (goq_pkg::CAPACITY)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (node_wr_addr),
        .wr_data (node_wr_data),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_data)
    );

    goq_ram #(
        .WIDTH (goq_pkg::NODE_W),
        .DEPTH (goq_pkg::GROUPS)
    ) u_glast_ram (
        .clk     (clk),
        .wr_en   (glast_wr_en),
        .wr_addr (glast_wr_addr),
        .wr_data (glast_wr_data),
        .rd_en   (glast_rd_en),
        .rd_addr (glast_rd_addr),
        .rd_data (glast_rd_data)
    );

    assign req.ready     = (state_reg == goq_pkg::ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.status    = out_status_reg;

    // The group field is exactly as wide as the group index.
    assign group_idx  = op_group_reg[goq_pkg::GIDX_W-1:0];
    assign group_here = present_reg[group_idx];

    // A new node comes from the free list when it holds any, else from the
    // slots never used so far.
    assign use_free  = (free_cnt_reg != '0);
    assign alloc_idx = use_free ? free_head_reg : fresh_reg[goq_pkg::NODE_W-1:0];

    // The new node is spliced into the middle when its group's last member is
    // queued but is not the tail; otherwise, in a non-empty queue, it is linked after link_idx and
    // becomes the new tail.
    assign splice   = group_here && (glast_rd_data != tail_reg);
    assign link_idx = group_here ? glast_rd_data : tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= goq_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            free_head_reg <= '0;
            free_cnt_reg  <= '0;
            fresh_reg     <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            free_head_reg <= free_head_next;
            free_cnt_reg  <= free_cnt_next;
            fresh_reg     <= fresh_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_value_reg   <= op_value_next;
        op_group_reg   <= op_group_next;
        node_idx_reg   <= node_idx_next;
        link_reg       <= link_next;
        splice_reg     <= splice_next;
        link_word_reg  <= link_word_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        free_head_next  = free_head_reg;
        free_cnt_next   = free_cnt_reg;
        fresh_next      = fresh_reg;
        present_next    = present_reg;
        out_valid_next  = out_valid_reg;
        op_value_next   = op_value_reg;
        op_group_next   = op_group_reg;
        node_idx_next   = node_idx_reg;
        link_next       = link_reg;
        splice_next     = splice_reg;
        link_word_next  = link_word_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        node_wr_en    = 1'b0;
        node_wr_addr  = '0;
        node_wr_data  = '0;
        node_rd_en    = 1'b0;
        node_rd_addr  = '0;
        glast_wr_en   = 1'b0;
        glast_wr_addr = '0;
        glast_wr_data = '0;
        glast_rd_en   = 1'b0;
        glast_rd_addr = '0;

        // A waiting response word leaves when the sink takes it.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            goq_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_value_next   = req.item_value;
                    op_group_next   = req.item_group;
                    res_value_next  = '0;
                    res_status_next = goq_pkg::STATUS_OK;
                    if (req.func == goq_pkg::FUNC_DEQ)
                    begin
                        if (occ_reg == '0)
                        begin
                            res_status_next = goq_pkg::STATUS_EMPTY;
                            state_next      = goq_pkg::ST_DONE;
                        end
                        else
                        begin
                            node_rd_en   = 1'b1;
                            node_rd_addr = head_reg;
                            state_next   = goq_pkg::ST_DQ_READ;
                        end
                    end
                    else
                    begin
                        if (occ_reg == goq_pkg::CAP_COUNT)
                        begin
                            res_status_next = goq_pkg::STATUS_FULL;
                            state_next      = goq_pkg::ST_DONE;
                        end
                        else
                        begin
                            // Fetch the group's last member and the link of
                            // the free-list head together.
                            glast_rd_en   = 1'b1;
                            glast_rd_addr = req.item_group[goq_pkg::GIDX_W-1:0];
                            node_rd_en    = 1'b1;
                            node_rd_addr  = free_head_reg;
                            state_next    = goq_pkg::ST_EQ_ALLOC;
                        end
                    end
                end
            end

            goq_pkg::ST_EQ_ALLOC:
            begin
                node_idx_next = alloc_idx;
                if (use_free)
                begin
                    free_head_next = node_rd_data.next;
                    free_cnt_next  = free_cnt_reg - 1'b1;
                end
                else
                begin
                    fresh_next = fresh_reg + 1'b1;
                end
                glast_wr_en   = 1'b1;
                glast_wr_addr = group_idx;
                glast_wr_data = alloc_idx;
                present_next[group_idx] = 1'b1;
                occ_next = occ_reg + 1'b1;

                if (!group_here && (occ_reg == '0))
                begin
                    // First value of an empty queue.
                    head_next    = alloc_idx;
                    tail_next    = alloc_idx;
                    node_wr_en   = 1'b1;
                    node_wr_addr = alloc_idx;
                    node_wr_data = '{value: op_value_reg, group: op_group_reg, next: '0};
                    state_next   = goq_pkg::ST_DONE;
                end
                else
                begin
                    link_next    = link_idx;
                    splice_next  = splice;
                    node_rd_en   = 1'b1;
                    node_rd_addr = link_idx;
                    if (!splice)
                    begin
                        tail_next    = alloc_idx;
                        node_wr_en   = 1'b1;
                        node_wr_addr = alloc_idx;
                        node_wr_data = '{value: op_value_reg, group: op_group_reg, next: '0};
                    end
                    state_next = goq_pkg::ST_EQ_SPLICE;
                end
            end

            goq_pkg::ST_EQ_SPLICE:
            begin
                link_word_next = '{value: node_rd_data.value, group: node_rd_data.group,
                                   next: node_idx_reg};
                node_wr_en = 1'b1;
                if (splice_reg)
                begin
                    // The new node takes over the link of the group's last member.
                    node_wr_addr = node_idx_reg;
                    node_wr_data = '{value: op_value_reg, group: op_group_reg,
                                     next: node_rd_data.next};
                    state_next   = goq_pkg::ST_EQ_LINK;
                end
                else
                begin
                    node_wr_addr = link_reg;
                    node_wr_data = '{value: node_rd_data.value, group: node_rd_data.group,
                                     next: node_idx_reg};
                    state_next   = goq_pkg::ST_DONE;
                end
            end

            goq_pkg::ST_EQ_LINK:
            begin
                node_wr_en   = 1'b1;
                node_wr_addr = link_reg;
                node_wr_data = link_word_reg;
                state_next   = goq_pkg::ST_DONE;
            end

            goq_pkg::ST_DQ_READ:
            begin
                // Return the head value and push its node onto the free list.
                res_value_next = node_rd_data.value;
                node_wr_en     = 1'b1;
                node_wr_addr   = head_reg;
                node_wr_data   = '{value: node_rd_data.value, group: node_rd_data.group,
                                   next: free_head_reg};
                head_next      = node_rd_data.next;
                free_head_next = head_reg;
                free_cnt_next  = free_cnt_reg + 1'b1;
                occ_next       = occ_reg - 1'b1;
                node_idx_next  = head_reg;
                op_group_next  = node_rd_data.group;
                glast_rd_en    = 1'b1;
                glast_rd_addr  = node_rd_data.group[goq_pkg::GIDX_W-1:0];
                state_next     = goq_pkg::ST_DQ_GROUP;
            end

            goq_pkg::ST_DQ_GROUP:
            begin
                // The group is no longer queued once its last member leaves.
                if (group_here && (glast_rd_data == node_idx_reg))
                begin
                    present_next[group_idx] = 1'b0;
                end
                state_next = goq_pkg::ST_DONE;
            end

            goq_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    state_next      = goq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = goq_pkg::ST_IDLE;
            end
        endcase
    end

    // Queued plus recycled nodes always account for every slot handed out.
    `GOQ_ASSERT_IMPL(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= goq_pkg::CAP_COUNT)
    `GOQ_ASSERT_IMPL(a_slot_count, clk, rst_n, 1'b1, (occ_reg + free_cnt_reg) == fresh_reg)
    `GOQ_ASSERT_IMPL(a_empty_no_group, clk, rst_n, (state_reg == goq_pkg::ST_IDLE) && (occ_reg == '0), present_reg == '0)
    `GOQ_ASSERT_NEXT(a_deq_shrinks, clk, rst_n, state_reg == goq_pkg::ST_DQ_READ, (occ_reg + 1'b1) == $past(occ_reg))

endmodule

// File: test/testbench.sv
// Self-checking testbench for the group ordered queue: directed table, then random fill, drain and mixing.
module testbench;
    import goq_pkg::*;

    // Clock period is 12 units, so half a period is 6.
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_WORDS = 880;
    // Sender gaps and receiver stalls slow each word down on average. Several times
    // the slowest plausible run still fits here.
    localparam int CYCLE_LIMIT = 200000;
    // The longest operation is a splice into the middle; this margin covers any straggler.
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    // One queued value as the team line sees it.
    typedef struct packed
    {
        logic signed [VALUE_W-1:0] value;
        logic [GIDX_W-1:0]         group;
    } member_t;

    // One response word: the value handed back and its status.
    typedef struct packed
    {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
    } answer_t;

    // One row of the directed table. When known is set, the answer is typed in
    // below; otherwise the team line model supplies it.
    typedef struct packed
    {
        func_t                     op;
        logic signed [VALUE_W-1:0] value;
        logic [GROUP_W-1:0]        group;
        logic                      known;
        answer_t                   answer;
    } plan_row_t;

    // The random part moves through these phases so that the queue gets filled
    // to capacity, overflowed, drained to empty and underflowed more than once.
    typedef enum logic [1:0]
    {
        FILLING,
        DRAINING,
        MIXING
    } phase_t;

    logic clk;
    logic rst_n;

    goq_req_if req_ch ();
    goq_rsp_if rsp_ch ();

    group_ordered_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model of the queue contents in order from head to tail. Members of a group
    // always sit together, so joining a group means going right behind its last
    // member, and a group whose last member has left simply no longer appears.
    member_t team_line[$];
    // Answers that the block still owes, oldest first.
    answer_t answers_due[$];
    // Rows of the directed table, in the order they are sent.
    plan_row_t directed_plan[$];

    int  mismatches;
    int  results_seen;
    int  cycle_count;
    // While set, neither side inserts idle cycles.
    bit  no_stall;

    always #HALF_PERIOD clk = ~clk;

    // Work out the answer to one request word and update the team line to match.
    function automatic void run_on_line(input func_t op,
                                        input logic signed [VALUE_W-1:0] value,
                                        input logic [GROUP_W-1:0] group,
                                        output answer_t answer);
        member_t arrival;
        int      spot;
        answer.value  = '0;
        answer.status = STATUS_OK;
        if (op == FUNC_ENQ)
        begin
            if (team_line.size() >= CAPACITY)
            begin
                answer.status = STATUS_FULL;
            end
            else
            begin
                arrival.value = value;
                arrival.group = GIDX_W'(int'(group) % GROUPS);
                // Walk back from the tail to just behind the group's last member.
                spot = team_line.size();
                while (spot > 0 && team_line[spot - 1].group != arrival.group)
                    spot--;
                if (spot == 0)
                    spot = team_line.size();
                team_line.insert(spot, arrival);
            end
        end
        else if (team_line.size() == 0)
        begin
            answer.status = STATUS_EMPTY;
        end
        else
        begin
            answer.value = team_line[0].value;
            team_line.delete(0);
        end
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input func_t op,
                                    input logic signed [VALUE_W-1:0] value,
                                    input logic [GROUP_W-1:0] group,
                                    input logic known,
                                    input logic signed [VALUE_W-1:0] want_value,
                                    input status_t want_status);
        plan_row_t row;
        row.op            = op;
        row.value         = value;
        row.group         = group;
        row.known         = known;
        row.answer.value  = want_value;
        row.answer.status = want_status;
        directed_plan.insert(directed_plan.size(), row);
    endfunction

    // Offer one request word, with random idle cycles ahead of it, and wait for
    // the block to take it. Called at a rising edge, returns at a rising edge.
    // The answer is booked at the falling edge where the handshake is seen,
    // before the block could possibly respond to it.
    task automatic offer_word(input func_t op,
                              input logic signed [VALUE_W-1:0] value,
                              input logic [GROUP_W-1:0] group,
                              input logic known,
                              input answer_t typed_answer);
        answer_t predicted;
        logic    took;
        while (!no_stall && $urandom_range(99) < 38)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= op;
        req_ch.item_value <= value;
        req_ch.item_group <= group;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = req_ch.ready;
            if (took)
            begin
                run_on_line(op, value, group, predicted);
                answers_due.insert(answers_due.size(), known ? typed_answer : predicted);
            end
            @(posedge clk);
        end
    endtask

    // Hold the request side idle until the block has answered every word.
    // The extra edge keeps the lowering of valid apart from any later raising.
    task automatic hold_until_answered();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    // Receiver side: ready drops at random, with odds of 38 in 100, unless stalls are off.
    always @(posedge clk)
        rsp_ch.ready <= no_stall || ($urandom_range(99) >= 38);

    // Result checking, sampled mid-cycle where every signal is settled.
    always @(negedge clk)
    begin
        answer_t due;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing outstanding: value %0d status %0d",
                             results_seen, rsp_ch.out_value, rsp_ch.status);
            end
            else
            begin
                due = answers_due[0];
                answers_due.delete(0);
                if (rsp_ch.out_value !== due.value || rsp_ch.status !== due.status)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d: expected value %0d status %0d, got value %0d status %0d",
                                 results_seen, due.value, due.status,
                                 rsp_ch.out_value, rsp_ch.status);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        phase_t                 phase;
        func_t                  op;
        logic signed [VALUE_W-1:0] value;
        logic [GROUP_W-1:0]     group;
        int                     enq_odds;
        int                     spills;
        int                     mix_left;
        int                     pick;

        clk                = 1'b0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_ENQ;
        req_ch.item_value <= '0;
        req_ch.item_group <= '0;
        mismatches         = 0;
        results_seen       = 0;
        no_stall           = 1'b0;

        // Directed table. Queue contents after each row are noted on the right,
        // head first. Some dequeue words carry odd field values on purpose,
        // since the block has to ignore them.
        add_row(FUNC_DEQ, -32'sd1, 7'd127,        // empty queue
                1'b1, 32'sd0, STATUS_EMPTY);
        add_row(FUNC_ENQ, 32'sh7FFF_FFFF, 7'd127, // MAX
                1'b1, 32'sd0, STATUS_OK);
        add_row(FUNC_ENQ, 32'sh8000_0000, 7'd0,   // MAX MIN
                1'b1, 32'sd0, STATUS_OK);
        // Group 127 already has MAX queued, which is not the tail: splice.
        add_row(FUNC_ENQ, 32'sd1, 7'd127,         // MAX 1 MIN
                1'b1, 32'sd0, STATUS_OK);
        // Group 0's last member is the tail, so this one extends the tail.
        add_row(FUNC_ENQ, -32'sd1, 7'd0,          // MAX 1 MIN -1
                1'b1, 32'sd0, STATUS_OK);
        add_row(FUNC_ENQ, 32'sd5, 7'd64,          // ... -1 5
                1'b1, 32'sd0, STATUS_OK);
        // Group 127 keeps a member after this one leaves.
        add_row(FUNC_DEQ, 32'sd0, 7'd0,           // 1 MIN -1 5
                1'b1, 32'sh7FFF_FFFF, STATUS_OK);
        // The last member of group 127 leaves here.
        add_row(FUNC_DEQ, 32'sh5555_5555, 7'h55,  // MIN -1 5
                1'b1, 32'sd1, STATUS_OK);
        // Group 127 is gone, so its next value has to go to the tail.
        add_row(FUNC_ENQ, 32'sd42, 7'd127,        // MIN -1 5 42
                1'b1, 32'sd0, STATUS_OK);
        add_row(FUNC_ENQ, 32'sd7, 7'd0,           // MIN -1 7 5 42
                1'b0, 32'sd0, STATUS_OK);
        add_row(FUNC_ENQ, 32'shAAAA_AAAA, 7'h2A,  // ... 42 AAAA
                1'b0, 32'sd0, STATUS_OK);
        add_row(FUNC_DEQ, 32'sd0, 7'd0,
                1'b1, 32'sh8000_0000, STATUS_OK);
        add_row(FUNC_DEQ, 32'sd0, 7'd0,
                1'b1, -32'sd1, STATUS_OK);
        add_row(FUNC_DEQ, 32'sd0, 7'd0,
                1'b1, 32'sd7, STATUS_OK);
        // Group 0 is empty again and rejoins at the tail.
        add_row(FUNC_ENQ, 32'sd0, 7'd0,           // 5 42 AAAA 0
                1'b0, 32'sd0, STATUS_OK);
        add_row(FUNC_DEQ, 32'sd0, 7'd0,
                1'b1, 32'sd5, STATUS_OK);
        add_row(FUNC_DEQ, 32'sd0, 7'd0,
                1'b1, 32'sd42, STATUS_OK);
        add_row(FUNC_DEQ, 32'sd0, 7'd0,
                1'b0, 32'sd0, STATUS_OK);
        add_row(FUNC_DEQ, 32'sd0, 7'd0,
                1'b1, 32'sd0, STATUS_OK);
        add_row(FUNC_DEQ, 32'sh0F0F_0F0F, 7'h0F,  // empty again
                1'b1, 32'sd0, STATUS_EMPTY);

        // Reset once; it is released mid-cycle, away from the rising edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            offer_word(directed_plan[i].op, directed_plan[i].value, directed_plan[i].group,
                       directed_plan[i].known, directed_plan[i].answer);

        // Let the directed part finish completely before random traffic starts.
        hold_until_answered();

        // Random part. Filling is enqueue-heavy and runs on a few hot groups so
        // that splices into the middle are common; it goes on past capacity to
        // see dropped words. Draining then runs the queue dry and past empty.
        // A short balanced stretch separates each round.
        phase    = FILLING;
        spills   = 0;
        mix_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // One long stretch where both sides run flat out.
            no_stall = (n >= 300 && n < 500);

            case (phase)
                FILLING:  enq_odds = 85;
                DRAINING: enq_odds = 15;
                default:  enq_odds = 50;
            endcase
            op = ($urandom_range(99) < enq_odds) ? FUNC_ENQ : FUNC_DEQ;

            pick = $urandom_range(9);
            if (pick == 0)
                value = 32'sh7FFF_FFFF;
            else if (pick == 1)
                value = 32'sh8000_0000;
            else
                value = $urandom;

            pick = $urandom_range(99);
            if (pick < 70)
                group = GROUP_W'($urandom_range(7));
            else if (pick < 90)
                group = GROUP_W'($urandom_range(127));
            else
                group = (pick < 95) ? 7'd0 : 7'd127;

            offer_word(op, value, group, 1'b0, '0);

            case (phase)
                FILLING:
                begin
                    if (team_line.size() == CAPACITY)
                        spills++;
                    if (spills >= 6)
                    begin
                        // Sender waits out every answer while the queue is full.
                        hold_until_answered();
                        phase  = DRAINING;
                        spills = 0;
                    end
                end
                DRAINING:
                begin
                    if (team_line.size() == 0)
                        spills++;
                    if (spills >= 6)
                    begin
                        phase    = MIXING;
                        spills   = 0;
                        mix_left = 60;
                    end
                end
                default:
                begin
                    mix_left--;
                    if (mix_left <= 0)
                        phase = FILLING;
                end
            endcase
        end

        // Wind down: wait for every answer, then a little longer to catch strays.
        no_stall = 1'b0;
        req_ch.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && answers_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: group_ordered_queue_top.f
+incdir+rtl
rtl/goq_pkg.sv
rtl/goq_req_if.sv
rtl/goq_rsp_if.sv
rtl/goq_ram.sv
rtl/group_ordered_queue_top.sv
test/testbench.sv
